// File: src/bmb_pkg.sv
// Shared types and constants for the box mean blur block.
// No dependencies.
package bmb_pkg;
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RX     = 2'd2;
  localparam logic [1:0] REG_RY     = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] gray_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blurred_level;
    logic       frame_end;
  } out_item_t;
endpackage

// File: src/bmb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/bmb_fifo.sv
// Short queue of input items between the front and the back.
// Depends on bmb_pkg.
module bmb_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              push,
  input  bmb_pkg::in_item_t push_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output bmb_pkg::in_item_t pop_data
);
  import bmb_pkg::*;
  in_item_t   q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  assign full = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign pop_data = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

// File: src/bmb_core.sv
// Back part: stores pixels in the row store and computes clipped window means.
// Depends on bmb_pkg and bmb_ram.
module bmb_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic [10:0]        frame_width,
  input  logic [10:0]        frame_height,
  input  logic [2:0]         radius_x,
  input  logic [2:0]         radius_y,
  input  logic               item_valid,
  input  bmb_pkg::in_item_t  item,
  output logic               item_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output bmb_pkg::out_item_t res
);
  import bmb_pkg::*;
  localparam int SLOTS = 2 * MAX_RADIUS + 2;
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int SW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS * MAX_WIDTH);
  localparam int RW = $clog2(MAX_RADIUS + 1) + 1;
  localparam int NW = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1) + 1);
  localparam int SUMW = NW + 8;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RD = 6'b000010, S_ACC = 6'b000100,
    S_DIV = 6'b001000, S_OUT = 6'b010000, S_WAIT = 6'b100000
  } state_t;
  state_t state_r, state_nxt;

  logic [XW-1:0] w, inc_r, outc_r, x_r, x0_r, x1_r, x0;
  logic [YW-1:0] h, inr_r, outr_r, y_r, y1_r, y0;
  logic [SW-1:0] slot_y_r, in_slot_r, out_slot_r, y0_slot;
  logic [RW-1:0] rx, ry;
  logic [SUMW-1:0] sum_r, rem_r;
  logic [NW-1:0] cnt_r;
  logic [7:0] q_r;
  logic [4:0] dbit_r;
  logic rd_pend_r, rd_last_r, frame_end_r;
  logic [7:0] rdata;
  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [XW+YW+4:0] tx, ty;
  logic complete, in_ok, last_out;
  logic [SUMW:0] trial;

  always_comb begin
    w = (frame_width == 11'd0) ? XW'(1) :
        (32'(frame_width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(frame_width);
    h = (frame_height == 11'd0) ? YW'(1) :
        (32'(frame_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(frame_height);
    rx = (32'(radius_x) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_x);
    ry = (32'(radius_y) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_y);
    tx = (32'(outc_r) + 32'(rx) > 32'(w) - 1) ? (XW+YW+5)'(w - XW'(1))
         : (XW+YW+5)'(outc_r) + (XW+YW+5)'(rx);
    ty = (32'(outr_r) + 32'(ry) > 32'(h) - 1) ? (XW+YW+5)'(h - YW'(1))
         : (XW+YW+5)'(outr_r) + (XW+YW+5)'(ry);
    y0 = (outr_r >= YW'(ry)) ? outr_r - YW'(ry) : '0;
    x0 = (outc_r >= XW'(rx)) ? outc_r - XW'(rx) : '0;
    // slot of the top window row, stepped back from the slot of the output row
    if (outr_r < YW'(ry)) y0_slot = '0;
    else if (32'(out_slot_r) >= 32'(ry)) y0_slot = SW'(32'(out_slot_r) - 32'(ry));
    else y0_slot = SW'(32'(out_slot_r) + SLOTS - 32'(ry));
    complete = (outr_r < h) && (outc_r < w) &&
               ((XW+YW+5)'(inr_r) > ty ||
                ((XW+YW+5)'(inr_r) == ty && (XW+YW+5)'(inc_r) > tx));
    in_ok = (item.req_type == REQ_PIXEL) && (inr_r < h) && (inc_r < w);
    last_out = (outr_r == h - YW'(1)) && (outc_r == w - XW'(1));
  end

  assign item_pop = (state_r == S_IDLE) && item_valid;
  assign ram_we = item_pop && in_ok;
  assign waddr = AW'(32'(in_slot_r) * MAX_WIDTH + 32'(inc_r));
  assign raddr = AW'(32'(slot_y_r) * MAX_WIDTH + 32'(x_r));
  assign trial = {rem_r, sum_r[SUMW-1]} - {{(SUMW+1-NW){1'b0}}, cnt_r};

  bmb_ram #(.WIDTH(8), .DEPTH(SLOTS * MAX_WIDTH)) u_ram (
    .clk, .we(ram_we), .waddr, .wdata(item.gray_level), .raddr, .rdata
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (item_valid) state_nxt = S_WAIT;
      S_WAIT: state_nxt = complete ? S_RD : S_IDLE;
      S_RD:   if (rd_last_r && !rd_pend_r) state_nxt = S_ACC;
      S_ACC:  state_nxt = S_DIV;
      S_DIV:  if (dbit_r == 5'd0) state_nxt = S_OUT;
      S_OUT:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_valid = state_r == S_OUT;
  assign res = '{blurred_level: q_r, frame_end: frame_end_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      inc_r <= '0; inr_r <= '0; outc_r <= '0; outr_r <= '0; in_slot_r <= '0;
      out_slot_r <= '0;
    end else if (restart) begin
      state_r <= S_IDLE;
      inc_r <= '0; inr_r <= '0; outc_r <= '0; outr_r <= '0; in_slot_r <= '0;
      out_slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        if (inc_r + XW'(1) >= w) begin
          inc_r <= '0; inr_r <= inr_r + YW'(1);
          in_slot_r <= (32'(in_slot_r) == SLOTS - 1) ? '0 : in_slot_r + SW'(1);
        end else inc_r <= inc_r + XW'(1);
      end
      if (state_r == S_OUT && res_ready) begin
        if (frame_end_r) begin
          inc_r <= '0; inr_r <= '0; outc_r <= '0; outr_r <= '0; in_slot_r <= '0;
          out_slot_r <= '0;
        end else if (outc_r + XW'(1) >= w) begin
          outc_r <= '0; outr_r <= outr_r + YW'(1);
          out_slot_r <= (32'(out_slot_r) == SLOTS - 1) ? '0 : out_slot_r + SW'(1);
        end else outc_r <= outc_r + XW'(1);
      end
    end
  end

  // window walk: one read per cycle, each read value accumulated in the cycle after its read
  always_ff @(posedge clk) begin
    case (state_r)
      S_WAIT: begin
        x0_r <= x0;
        y1_r <= YW'(ty); x1_r <= XW'(tx);
        y_r <= y0;
        x_r <= x0;
        slot_y_r <= y0_slot;
        sum_r <= '0; rd_pend_r <= 1'b0; rd_last_r <= 1'b0;
        frame_end_r <= last_out;
        cnt_r <= NW'((32'(ty) - 32'(y0) + 1) * (32'(tx) - 32'(x0) + 1));
      end
      S_RD: begin
        if (rd_pend_r) sum_r <= sum_r + SUMW'(rdata);
        rd_pend_r <= !rd_last_r;
        if (!rd_last_r) begin
          if (x_r == x1_r) begin
            x_r <= x0_r;
            if (y_r == y1_r) rd_last_r <= 1'b1;
            else begin
              y_r <= y_r + YW'(1);
              slot_y_r <= (32'(slot_y_r) == SLOTS - 1) ? '0 : slot_y_r + SW'(1);
            end
          end else x_r <= x_r + XW'(1);
        end
      end
      S_ACC: begin
        sum_r <= sum_r + SUMW'(cnt_r >> 1);
        rem_r <= '0; q_r <= '0; dbit_r <= 5'(SUMW);
      end
      S_DIV: if (dbit_r != 5'd0) begin
        if (!trial[SUMW]) begin
          rem_r <= trial[SUMW-1:0]; q_r <= {q_r[6:0], 1'b1};
        end else begin
          rem_r <= {rem_r[SUMW-2:0], sum_r[SUMW-1]}; q_r <= {q_r[6:0], 1'b0};
        end
        sum_r <= sum_r << 1;
        dbit_r <= dbit_r - 5'd1;
      end
      default: ;
    endcase
  end
endmodule

// File: src/bmb_front.sv
// Front part: accepts items, holds configuration and queues items for the back.
// Depends on bmb_pkg and bmb_fifo.
module bmb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic [7:0]        in_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [10:0]       cfg_data,
  output logic              restart,
  output logic [10:0]       frame_width,
  output logic [10:0]       frame_height,
  output logic [2:0]        radius_x,
  output logic [2:0]        radius_y,
  output logic              item_valid,
  output bmb_pkg::in_item_t item,
  input  logic              item_pop
);
  import bmb_pkg::*;
  logic full, empty;
  in_item_t pd;
  assign cfg_ready = 1'b1;
  assign restart = cfg_valid;
  assign in_tready = !full;
  assign pd.req_type = in_tuser;
  assign pd.gray_level = in_tdata;
  assign item_valid = !empty;
  bmb_fifo u_q (.clk, .rst_n, .flush(1'b0), .push(in_tvalid && !full), .push_data(pd),
                .full, .empty, .pop(item_pop), .pop_data(item));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width <= 11'd1024; frame_height <= 11'd1024;
      radius_x <= 3'd1; radius_y <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  frame_width <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        REG_RX:     radius_x <= cfg_data[2:0];
        REG_RY:     radius_y <= cfg_data[2:0];
        default: ;
      endcase
    end
  end
endmodule

// File: src/box_mean_blur_clipped.sv
// Top level of the clipped box mean blur.
// Depends on bmb_pkg, bmb_front, bmb_core.
//  channel | dir | payload
//  in_     | in  | tdata = gray_level, tuser = req_type
//  out_    | out | tdata = blurred_level, tlast = frame_end
//  cfg_    | in  | index 0..3, data 11 bits
// An item with a result does one row store read per window pixel, then one divider
// step per bit of the sum width (16 bits at the default sizes). An item without a
// result does neither in the back part.
// Reset is synchronous; a queue of four items lets the input run ahead.
// A stalled out_ holds the back part; configuration restarts the frame.
module box_mean_blur_clipped #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] gray_level
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] blurred_level
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import bmb_pkg::*;
  logic restart, item_valid, item_pop;
  logic [10:0] fw, fh;
  logic [2:0] rx, ry;
  in_item_t item;
  out_item_t res;
  bmb_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .restart, .frame_width(fw),
    .frame_height(fh), .radius_x(rx), .radius_y(ry), .item_valid, .item, .item_pop);
  bmb_core #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS))
  u_core (.clk, .rst_n, .restart, .frame_width(fw), .frame_height(fh), .radius_x(rx),
    .radius_y(ry), .item_valid, .item, .item_pop, .res_valid(out_tvalid),
    .res_ready(out_tready), .res);
  assign out_tdata = res.blurred_level;
  assign out_tlast = res.frame_end;
endmodule

// File: src/bmb_checker.sv
// Port-level checker for the box mean blur, bound to the top level.
// Depends on box_mean_blur_clipped.
module bmb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("results back to back");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config not ready");
endmodule

bind box_mean_blur_clipped bmb_checker u_chk (.clk, .rst_n, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast, .cfg_ready);
